FILE: design/sliding_window_send_tracker_core_defines.svh
// Assertion macros shared by the checker of the send tracker.
// The macros expect signals named clk and rst_n in the scope where they are used.
`ifndef SLIDING_WINDOW_SEND_TRACKER_CORE_DEFINES_SVH
`define SLIDING_WINDOW_SEND_TRACKER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SWST_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define SWST_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked while reset is applied.
`define SWST_AST_NXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: design/swst_pkg.sv
// Package of the sliding-window send tracker: item kinds, sequencer states,
// result word layout and default sizes. It depends on nothing else.
package swst_pkg;

  localparam int SLOTS_DEF       = 8;
  localparam int MAX_PAYLOAD_DEF = 64;

  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int SEQ_W       = 16;
  localparam int LEN_W       = 7;
  localparam int TIME_W      = 32;
  localparam int META_W      = SEQ_W + LEN_W;

  typedef enum logic [KIND_W-1:0] {
    KIND_CHUNK = 2'd0,
    KIND_ACK   = 2'd1,
    KIND_SENT  = 2'd2,
    KIND_NONE  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ALLOC,
    ST_ACK_RD,
    ST_ACK_CMP,
    ST_FIND,
    ST_FIND_RD,
    ST_DONE
  } state_t;

  // The last member sits in the lowest bits of the result word.
  typedef struct packed {
    logic             bad_slot;
    logic [7:0]       current_window;
    logic [3:0]       flight_count;
    logic [LEN_W-1:0] next_length;
    logic [SEQ_W-1:0] next_seq;
    logic [2:0]       next_slot;
    logic             next_valid;
    logic [3:0]       acked_count;
    logic [SEQ_W-1:0] new_seqno;
    logic [2:0]       new_slot;
    logic             accepted;
  } result_t;

endpackage

FILE: design/swst_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// It depends on nothing else.
module swst_ram #(
  parameter int W = 8,
  parameter int D = 8
) (
  input  logic                            clk,
  input  logic                            we,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  logic [W-1:0]                    wdata,
  input  logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic [W-1:0]                    rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/sliding_window_send_tracker_core.sv
// Sliding-window send tracker: slot table of a sender with cumulative acks.
// Depends on swst_pkg and on swst_ram for the per-slot sequence, length and time.
//
// Input channel in_*: one word per event. in_tuser holds the kind (chunk, ack,
// sent); in_tdata holds the chunk length, ack number, advertised window, sent
// slot and send time. Output channel out_*: exactly one result word per input
// word, in order, holding the allocation, ack count, lowest unsent slot and
// the counters after the event.
// A small sequencer walks the slots one at a time with a single compare unit
// and a single RAM read port, so the block takes one word at a time and is not
// ready while it works. The ack walk visits each slot in a read state and
// then in a compare state, because every sequence number comes from the RAM.
// The result sits in an output register, so a new word is accepted while the
// previous result still waits; if the receiver stalls, the block holds its
// finished result until the register frees up and does not accept more words.
// Synchronous reset frees every slot, clears the counters and sets the window
// to SLOTS; the RAM contents need no clearing because no slot is read before
// it has been written.
module sliding_window_send_tracker_core
  import swst_pkg::*;
#(
  parameter int SLOTS       = SLOTS_DEF,
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // kind [1:0]
  input  logic [KIND_W-1:0]      in_tuser,
  // chunk_len [6:0], ack_number [22:7], advertised_window [30:23],
  // sent_slot [33:31], send_time_us [65:34], zero fill [71:66]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // accepted [0], new_slot [3:1], new_seqno [19:4], acked_count [23:20],
  // next_valid [24], next_slot [27:25], next_seq [43:28], next_length [50:44],
  // flight_count [54:51], current_window [62:55], bad_slot [63]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  state_t state_r, state_nxt;

  logic [IW-1:0]     idx_r, idx_nxt;
  logic [SLOTS-1:0]  free_r, free_nxt;
  logic [SLOTS-1:0]  sent_r, sent_nxt;
  logic [SEQ_W-1:0]  seq_ctr_r, seq_ctr_nxt;
  logic [CW-1:0]     occ_r, occ_nxt;
  logic [7:0]        win_r, win_nxt;
  logic [CW-1:0]     acked_r, acked_nxt;
  logic [LEN_W-1:0]  clen_r, clen_nxt;
  logic [SEQ_W-1:0]  ackno_r, ackno_nxt;
  logic [7:0]        adv_r, adv_nxt;
  result_t           work_r, work_nxt;
  result_t           out_r, out_nxt;
  logic              out_valid_r, out_valid_nxt;

  logic              in_fire;
  kind_t             in_kind;
  logic [LEN_W-1:0]  in_clen;
  logic [SEQ_W-1:0]  in_ackno;
  logic [7:0]        in_adv;
  logic [2:0]        in_sslot;
  logic [TIME_W-1:0] in_stime;
  logic [IW-1:0]     sent_idx;
  logic              sent_ok;
  logic              win_ok;
  logic              last;
  logic              found;
  logic              out_free;
  logic [LEN_W-1:0]  len_sat;
  logic [31:0]       idx_ext;
  logic [31:0]       occ_ext;
  logic [31:0]       acked_ext;

  logic              meta_we;
  logic [META_W-1:0] meta_wdata;
  logic [META_W-1:0] meta_rdata;
  logic [IW-1:0]     meta_raddr;
  logic              time_we;

  assign in_kind  = kind_t'(in_tuser);
  assign in_clen  = in_tdata[6:0];
  assign in_ackno = in_tdata[22:7];
  assign in_adv   = in_tdata[30:23];
  assign in_sslot = in_tdata[33:31];
  assign in_stime = in_tdata[65:34];

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;

  assign sent_idx  = IW'(in_sslot);
  assign sent_ok   = (32'(in_sslot) < SLOTS) && !free_r[sent_idx];
  assign occ_ext   = 32'(occ_r);
  assign idx_ext   = 32'(idx_r);
  assign acked_ext = 32'(acked_r);
  assign win_ok    = (in_clen != '0) && (occ_ext < 32'(win_r));
  assign last      = (idx_r == LAST_IDX);
  assign found     = !free_r[idx_r] && !sent_r[idx_r];
  assign out_free  = !out_valid_r || out_tready;
  assign len_sat   = (32'(in_clen) > MAX_PAYLOAD) ? LEN_W'(MAX_PAYLOAD) : in_clen;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          case (in_kind)
            KIND_CHUNK: state_nxt = win_ok ? ST_ALLOC : ST_FIND;
            KIND_ACK:   state_nxt = ST_ACK_RD;
            default:    state_nxt = ST_FIND;
          endcase
        end
      end
      ST_ALLOC: begin
        if (free_r[idx_r] || last) begin
          state_nxt = ST_FIND;
        end
      end
      ST_ACK_RD:  state_nxt = ST_ACK_CMP;
      ST_ACK_CMP: state_nxt = last ? ST_FIND : ST_ACK_RD;
      ST_FIND: begin
        if (found) begin
          state_nxt = ST_FIND_RD;
        end else if (last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_FIND_RD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    idx_nxt       = idx_r;
    free_nxt      = free_r;
    sent_nxt      = sent_r;
    seq_ctr_nxt   = seq_ctr_r;
    occ_nxt       = occ_r;
    win_nxt       = win_r;
    acked_nxt     = acked_r;
    clen_nxt      = clen_r;
    ackno_nxt     = ackno_r;
    adv_nxt       = adv_r;
    work_nxt      = work_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_tready;
    meta_we       = 1'b0;
    meta_wdata    = {seq_ctr_r, clen_r};
    meta_raddr    = idx_r;
    time_we       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt   = '0;
          acked_nxt = '0;
          clen_nxt  = len_sat;
          ackno_nxt = in_ackno;
          adv_nxt   = in_adv;
          work_nxt  = '0;
          if (in_kind == KIND_SENT) begin
            if (sent_ok) begin
              time_we            = 1'b1;
              sent_nxt[sent_idx] = 1'b1;
            end else begin
              work_nxt.bad_slot = 1'b1;
            end
          end
        end
      end
      ST_ALLOC: begin
        if (free_r[idx_r]) begin
          meta_we            = 1'b1;
          free_nxt[idx_r]    = 1'b0;
          sent_nxt[idx_r]    = 1'b0;
          occ_nxt            = occ_r + 1'b1;
          seq_ctr_nxt        = seq_ctr_r + 1'b1;
          work_nxt.accepted  = 1'b1;
          work_nxt.new_slot  = idx_ext[2:0];
          work_nxt.new_seqno = seq_ctr_r;
          idx_nxt            = '0;
        end else begin
          idx_nxt = last ? '0 : idx_r + 1'b1;
        end
      end
      ST_ACK_CMP: begin
        if (!free_r[idx_r] && (meta_rdata[META_W-1:LEN_W] <= ackno_r)) begin
          free_nxt[idx_r] = 1'b1;
          sent_nxt[idx_r] = 1'b0;
          acked_nxt       = acked_r + 1'b1;
          if (occ_r != '0) begin
            occ_nxt = occ_r - 1'b1;
          end
        end
        if (last) begin
          win_nxt = adv_r;
          idx_nxt = '0;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIND: begin
        if (found) begin
          work_nxt.next_valid = 1'b1;
          work_nxt.next_slot  = idx_ext[2:0];
        end else if (!last) begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      ST_FIND_RD: begin
        work_nxt.next_seq    = meta_rdata[META_W-1:LEN_W];
        work_nxt.next_length = meta_rdata[LEN_W-1:0];
      end
      ST_DONE: begin
        if (out_free) begin
          out_nxt                = work_r;
          out_nxt.acked_count    = acked_ext[3:0];
          out_nxt.flight_count   = occ_ext[3:0];
          out_nxt.current_window = win_r;
          out_valid_nxt          = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      free_r      <= '1;
      sent_r      <= '0;
      seq_ctr_r   <= '0;
      occ_r       <= '0;
      win_r       <= 8'(SLOTS);
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      free_r      <= free_nxt;
      sent_r      <= sent_nxt;
      seq_ctr_r   <= seq_ctr_nxt;
      occ_r       <= occ_nxt;
      win_r       <= win_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acked_r <= acked_nxt;
    clen_r  <= clen_nxt;
    ackno_r <= ackno_nxt;
    adv_r   <= adv_nxt;
    work_r  <= work_nxt;
    out_r   <= out_nxt;
  end

  swst_ram #(
    .W (META_W),
    .D (SLOTS)
  ) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (idx_r),
    .wdata (meta_wdata),
    .raddr (meta_raddr),
    .rdata (meta_rdata)
  );

  swst_ram #(
    .W (TIME_W),
    .D (SLOTS)
  ) u_time_ram (
    .clk   (clk),
    .we    (time_we),
    .waddr (sent_idx),
    .wdata (in_stime),
    .raddr (sent_idx),
    .rdata ()
  );

endmodule

FILE: design/swst_chk.sv
// Port-level checker for the send tracker, bound to its top level below.
// Depends on swst_pkg and on the assertion macros in the defines header.
`include "sliding_window_send_tracker_core_defines.svh"

module swst_chk
  import swst_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic [KIND_W-1:0]      in_tuser,
  input logic [IN_TDATA_W-1:0]  in_tdata,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  result_t res;

  assign res = result_t'(out_tdata);

  `SWST_AST_NXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata), "Result word changed while stalled.")
  `SWST_AST_NXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready, "Input word accepted while the previous one is still in work.")
  `SWST_AST_IMP(a_bad_alone, out_tvalid && res.bad_slot, !res.accepted && res.acked_count == 4'd0, "Bad slot reported together with an allocation or an ack.")
  `SWST_AST_IMP(a_next_zero, out_tvalid && !res.next_valid, res.next_slot == 3'd0 && res.next_seq == '0 && res.next_length == '0, "Next segment fields set without a next segment.")
  `SWST_AST_NXT_ALWAYS(a_reset_quiet, !rst_n, !out_tvalid, "Result word shown right after reset.")

endmodule

bind sliding_window_send_tracker_core swst_chk u_swst_chk (.*);
